FILE: design/fqs_pkg.sv
// Shared constants, operation codes and status codes for the searchable FIFO queue.
`default_nettype none

package fqs_pkg;

  localparam int FQS_DEPTH = 16;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

FILE: design/fqs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/fifo_queue_with_search.sv
// Top level of the searchable FIFO queue: pointers, sequencer, compare unit and entry RAM.
//
// A command beat is taken when start is high and busy is low; each command gives exactly
// one result beat, marked by out_valid for one cycle, which the receiver must take.
// Enqueue, clear, query, undefined codes, the full and empty error cases, a search of
// an empty queue and a dequeue that leaves the queue empty are answered straight from
// idle, with the result in the next cycle. A dequeue that leaves entries behind goes
// through the DWAIT state, since the new front entry is read from the entry RAM through
// its registered read port. A search walks the stored entries from oldest to newest
// through that same read port and one shared 32-bit comparator, one entry per cycle,
// and stops at the first match or at the newest entry. busy stays high while a dequeue or a search runs.
// The count output is the occupancy masked to five bits.
`default_nettype none

module fifo_queue_with_search
  import fqs_pkg::*;
#(
  parameter int DEPTH = FQS_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic        [OP_W-1:0]     in_operation,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  output logic                            out_valid,
  output logic                            out_is_empty,
  output logic             [COUNT_W-1:0]  out_count,
  output logic signed      [VALUE_W-1:0]  out_front_value,
  output logic signed      [VALUE_W-1:0]  out_rear_value,
  output logic                            out_found,
  output logic             [STATUS_W-1:0] out_status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
  localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DWAIT = 2'd1;
  localparam logic [1:0] S_SCMP  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [PTR_W-1:0]   srch_ptr_r, srch_ptr_nxt;
  logic [OCC_W-1:0]   srch_cnt_r, srch_cnt_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [VALUE_W-1:0] front_r, front_nxt;
  logic [VALUE_W-1:0] rear_r, rear_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               found_r, found_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic               accept;
  logic               is_full;
  logic               is_zero;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   tail_inc;
  logic [PTR_W-1:0]   srch_inc;
  logic               ram_we;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;
  logic               key_match;
  logic               srch_last;
  logic [OCC_W+COUNT_W-1:0] count_ext;

  assign accept   = start && (state_r == S_IDLE);
  assign is_full  = (occ_r == OCC_FULL);
  assign is_zero  = (occ_r == '0);
  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
  assign srch_inc = (srch_ptr_r == PTR_LAST) ? '0 : srch_ptr_r + PTR_W'(1);

  assign key_match = (ram_rdata == key_r);
  assign srch_last = (srch_cnt_r == (occ_r - OCC_ONE));

  assign ram_we    = accept && (in_operation == OP_ENQUEUE) && !is_full;
  assign ram_re    = 1'b1;
  assign ram_raddr = (state_r == S_IDLE) ?
                     ((in_operation == OP_DEQUEUE) ? head_inc : head_r) : srch_inc;

  fqs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_r),
    .wr_data (in_value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    srch_ptr_nxt  = srch_ptr_r;
    srch_cnt_nxt  = srch_cnt_r;
    key_nxt       = key_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    out_valid_nxt = 1'b0;
    found_nxt     = found_r;
    status_nxt    = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          found_nxt  = 1'b0;
          status_nxt = ST_DONE;
          priority if (in_operation == OP_ENQUEUE) begin
            out_valid_nxt = 1'b1;
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              tail_nxt = tail_inc;
              occ_nxt  = occ_r + OCC_ONE;
              rear_nxt = in_value;
              if (is_zero) begin
                front_nxt = in_value;
              end
            end
          end else if (in_operation == OP_DEQUEUE) begin
            if (is_zero) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_EMPTY;
            end else begin
              head_nxt = head_inc;
              occ_nxt  = occ_r - OCC_ONE;
              if (occ_r == OCC_ONE) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_DWAIT;
              end
            end
          end else if (in_operation == OP_CLEAR) begin
            out_valid_nxt = 1'b1;
            head_nxt      = '0;
            tail_nxt      = '0;
            occ_nxt       = '0;
          end else if (in_operation == OP_SEARCH) begin
            if (is_zero) begin
              out_valid_nxt = 1'b1;
            end else begin
              key_nxt      = in_value;
              srch_ptr_nxt = head_r;
              srch_cnt_nxt = '0;
              state_nxt    = S_SCMP;
            end
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_DWAIT: begin
        front_nxt     = ram_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SCMP: begin
        if (key_match || srch_last) begin
          found_nxt     = key_match;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          srch_ptr_nxt = srch_inc;
          srch_cnt_nxt = srch_cnt_r + OCC_ONE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    srch_ptr_r <= srch_ptr_nxt;
    srch_cnt_r <= srch_cnt_nxt;
    key_r      <= key_nxt;
    front_r    <= front_nxt;
    rear_r     <= rear_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
  end

  assign count_ext = {{COUNT_W{1'b0}}, occ_r};

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_is_empty    = is_zero;
  assign out_count       = count_ext[COUNT_W-1:0];
  assign out_front_value = is_zero ? '0 : signed'(front_r);
  assign out_rear_value  = is_zero ? '0 : signed'(rear_r);
  assign out_found       = found_r;
  assign out_status      = status_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL)
    else $error("occupancy exceeds queue depth");

  a_cmd_answered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || busy))
    else $error("accepted command neither answered nor in progress");

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCMP) |-> (srch_cnt_r < occ_r))
    else $error("search walked past the stored entries");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_operation == OP_ENQUEUE) && !is_full) |=>
      (occ_r == $past(occ_r) + OCC_ONE))
    else $error("enqueue did not raise occupancy by one");

  a_busy_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCMP) |-> !out_valid_r || $past(state_r) == S_IDLE)
    else $error("result strobe during a running search");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the searchable FIFO queue: a directed table, then random commands.
module tb_top;
  import fqs_pkg::*;

  localparam int IDX_W        = $clog2(FQS_DEPTH);
  localparam int N_DIR        = 18;
  localparam int PHASE_ITEMS  = 372;
  localparam int SETTLE       = 2 * FQS_DEPTH + 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef logic signed [VALUE_W-1:0] word_t;

  localparam word_t WORD_MAX     = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN     = 32'sh8000_0000;
  localparam word_t WORD_NEG_ONE = 32'shFFFF_FFFF;

  typedef struct packed {
    logic                is_empty;
    logic [COUNT_W-1:0]  count;
    word_t               front_value;
    word_t               rear_value;
    logic                found;
    logic [STATUS_W-1:0] status;
  } queue_view_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    word_t           value;
    int              reps;
    bit              rnd_value;
    bit              typed;
    queue_view_t     want;
  } stim_row_t;

  localparam queue_view_t NO_VIEW       = '0;
  localparam queue_view_t VIEW_EMPTY    = '{1'b1, 5'd0, 32'sd0, 32'sd0, 1'b0, ST_DONE};
  localparam queue_view_t VIEW_DEQ_NONE = '{1'b1, 5'd0, 32'sd0, 32'sd0, 1'b0, ST_EMPTY};

  stim_row_t dir_rows [N_DIR] = '{
    '{OP_QUERY,   32'sd0,       1,             1'b0, 1'b1, VIEW_EMPTY},
    '{OP_DEQUEUE, 32'sd0,       1,             1'b0, 1'b1, VIEW_DEQ_NONE},
    '{OP_SEARCH,  32'sd0,       1,             1'b0, 1'b1, VIEW_EMPTY},
    '{OP_ENQUEUE, WORD_MAX,     1,             1'b0, 1'b1,
      '{1'b0, 5'd1, WORD_MAX, WORD_MAX, 1'b0, ST_DONE}},
    '{OP_ENQUEUE, WORD_MIN,     1,             1'b0, 1'b1,
      '{1'b0, 5'd2, WORD_MAX, WORD_MIN, 1'b0, ST_DONE}},
    '{OP_SEARCH,  WORD_MIN,     1,             1'b0, 1'b1,
      '{1'b0, 5'd2, WORD_MAX, WORD_MIN, 1'b1, ST_DONE}},
    '{OP_SEARCH,  32'sd0,       1,             1'b0, 1'b0, NO_VIEW},
    '{OP_SPARE_5, WORD_NEG_ONE, 1,             1'b0, 1'b0, NO_VIEW},
    '{OP_SPARE_7, WORD_MIN,     1,             1'b0, 1'b0, NO_VIEW},
    '{OP_DEQUEUE, 32'sd0,       1,             1'b0, 1'b0, NO_VIEW},
    '{OP_ENQUEUE, 32'sd0,       FQS_DEPTH - 1, 1'b1, 1'b0, NO_VIEW},
    '{OP_ENQUEUE, WORD_NEG_ONE, 1,             1'b0, 1'b0, NO_VIEW},
    '{OP_SEARCH,  WORD_NEG_ONE, 1,             1'b0, 1'b0, NO_VIEW},
    '{OP_CLEAR,   32'sd0,       1,             1'b0, 1'b1, VIEW_EMPTY},
    '{OP_CLEAR,   32'sd0,       1,             1'b0, 1'b1, VIEW_EMPTY},
    '{OP_ENQUEUE, WORD_NEG_ONE, 1,             1'b0, 1'b1,
      '{1'b0, 5'd1, WORD_NEG_ONE, WORD_NEG_ONE, 1'b0, ST_DONE}},
    '{OP_SEARCH,  WORD_NEG_ONE, 1,             1'b0, 1'b1,
      '{1'b0, 5'd1, WORD_NEG_ONE, WORD_NEG_ONE, 1'b1, ST_DONE}},
    '{OP_DEQUEUE, 32'sd0,       1,             1'b0, 1'b1, VIEW_EMPTY}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_operation;
  word_t               in_value;
  logic                out_valid;
  logic                out_is_empty;
  logic [COUNT_W-1:0]  out_count;
  word_t               out_front_value;
  word_t               out_rear_value;
  logic                out_found;
  logic [STATUS_W-1:0] out_status;

  word_t               q_mem [FQS_DEPTH];
  logic [IDX_W-1:0]    q_head;
  logic [IDX_W-1:0]    q_tail;
  logic [COUNT_W-1:0]  q_occ;

  queue_view_t         pending_views [$];
  int                  mismatch_cnt = 0;
  int                  idle_pct;
  int                  cycle_cnt;

  fifo_queue_with_search i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_is_empty    (out_is_empty),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_found       (out_found),
    .out_status      (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic queue_view_t apply_command(input logic [OP_W-1:0] op, input word_t val);
    queue_view_t v;
    int          i;
    v = '0;
    v.status = ST_DONE;
    case (op)
      OP_ENQUEUE: begin
        if (q_occ == FQS_DEPTH) begin
          v.status = ST_FULL;
        end else begin
          q_mem[q_tail] = val;
          q_tail = (q_tail == IDX_W'(FQS_DEPTH - 1)) ? '0 : q_tail + 1'b1;
          q_occ = q_occ + 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (q_occ == 0) begin
          v.status = ST_EMPTY;
        end else begin
          q_head = (q_head == IDX_W'(FQS_DEPTH - 1)) ? '0 : q_head + 1'b1;
          q_occ = q_occ - 1'b1;
        end
      end
      OP_CLEAR: begin
        q_head = '0;
        q_tail = '0;
        q_occ = '0;
      end
      OP_SEARCH: begin
        for (i = 0; i < int'(q_occ); i++) begin
          if (q_mem[IDX_W'((int'(q_head) + i) % FQS_DEPTH)] == val) v.found = 1'b1;
        end
      end
      default: ;
    endcase
    v.is_empty = (q_occ == 0);
    v.count = q_occ;
    if (q_occ != 0) begin
      v.front_value = q_mem[q_head];
      v.rear_value = q_mem[(q_tail == 0) ? IDX_W'(FQS_DEPTH - 1) : q_tail - 1'b1];
    end
    return v;
  endfunction

  task automatic issue_command(input logic [OP_W-1:0] op, input word_t val, input bit typed,
                               input queue_view_t want);
    queue_view_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_command(op, val);
    pending_views.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string field_name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT) begin
        $display("mismatch in %s: expected %0h, got %0h", field_name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    queue_view_t want;
    if (rst_n && out_valid) begin
      if (pending_views.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT) begin
          $display("result beat with nothing expected: count %0d", out_count);
        end
      end else begin
        want = pending_views.pop_front();
        check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(out_is_empty));
        check_field("count", VALUE_W'(want.count), VALUE_W'(out_count));
        check_field("front_value", want.front_value, out_front_value);
        check_field("rear_value", want.rear_value, out_rear_value);
        check_field("found", VALUE_W'(want.found), VALUE_W'(out_found));
        check_field("status", VALUE_W'(want.status), VALUE_W'(out_status));
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int              phase_idle [3];
    int              r;
    int              k;
    int              n;
    int              phase;
    int              roll;
    int              bias;
    int              enq_pct;
    int              deq_pct;
    logic [OP_W-1:0] op;
    word_t           val;
    phase_idle = '{32, 85, 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_QUERY;
    in_value = '0;
    idle_pct = phase_idle[0];
    bias = 2;
    q_head = '0;
    q_tail = '0;
    q_occ = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < N_DIR; r++) begin
      for (k = 0; k < dir_rows[r].reps; k++) begin
        issue_command(dir_rows[r].op,
                      dir_rows[r].rnd_value ? word_t'($urandom) : dir_rows[r].value,
                      dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Each phase runs biased stretches that fill, drain or churn the queue, then lets it settle.
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = phase_idle[phase];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) bias = $urandom_range(2);
        enq_pct = (bias == 0) ? 60 : (bias == 1) ? 15 : 37;
        deq_pct = (bias == 0) ? 15 : (bias == 1) ? 60 : 37;
        roll = $urandom_range(99);
        if (roll < enq_pct) begin
          op = OP_ENQUEUE;
        end else if (roll < enq_pct + deq_pct) begin
          op = OP_DEQUEUE;
        end else if (roll < 94) begin
          op = OP_SEARCH;
        end else if (roll < 96) begin
          op = OP_QUERY;
        end else if (roll < 97) begin
          op = OP_CLEAR;
        end else begin
          case ($urandom_range(2))
            0: op = OP_SPARE_5;
            1: op = OP_SPARE_6;
            default: op = OP_SPARE_7;
          endcase
        end
        case ($urandom_range(39))
          0: val = WORD_MIN;
          1: val = WORD_MAX;
          2: val = '0;
          3: val = WORD_NEG_ONE;
          default: val = $urandom;
        endcase
        if (op == OP_SEARCH && q_occ != 0 && $urandom_range(99) < 70) begin
          val = q_mem[IDX_W'((int'(q_head) + $urandom_range(int'(q_occ) - 1)) % FQS_DEPTH)];
          if ($urandom_range(99) < 25) val = val ^ (word_t'(1) << $urandom_range(VALUE_W - 1));
        end
        issue_command(op, val, 1'b0, NO_VIEW);
      end
      start <= 1'b0;
      @(posedge clk);
      while (pending_views.size() != 0) @(posedge clk);
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0 && pending_views.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/fqs_pkg.sv
design/fqs_ram.sv
design/fifo_queue_with_search.sv
test/tb_top.sv
